FILE: sv/hjb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hjb_pkg
// Shared types, codes and default sizes for the hash join build/probe unit.
// ----------------------------------------------------------------------------
package hjb_pkg;

    // Default table geometry
    localparam int unsigned NB_BUCKETS_DEF   = 1024;
    localparam int unsigned BUCKET_DEPTH_DEF = 16;

    // Field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] tuple_key;
        logic [DATA_W-1:0] tuple_val;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   build_key;
        logic [DATA_W-1:0]   build_val;
        logic [DATA_W-1:0]   probe_key;
        logic [DATA_W-1:0]   probe_val;
        logic                last;
    } t_out_word;

endpackage
`default_nettype wire

FILE: sv/hjb_rem_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hjb_rem_unit
// Bucket index unit: remainder of a 32-bit join value by the bucket count.
// A power-of-two bucket count keeps the low bits (mask). Any other count holds
// the value, multiplies by a fixed-point reciprocal for the quotient, then
// subtracts quotient times count in the low bits.
// ----------------------------------------------------------------------------
module hjb_rem_unit #(
    parameter int unsigned NB_BUCKETS = hjb_pkg::NB_BUCKETS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hjb_pkg::DATA_W-1:0]    i_val,
    output logic                               o_done,
    output logic [$clog2(NB_BUCKETS)-1:0]      o_rem
);

    localparam int unsigned BW = $clog2(NB_BUCKETS);

    generate
        if ((NB_BUCKETS & (NB_BUCKETS - 1)) == 0) begin : g_mask
            logic          r_done;
            logic [BW-1:0] r_rem;

            // Flag completion in the cycle after start
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            // Keep the low bits of the value
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_val[BW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_recip
            localparam int unsigned DW = hjb_pkg::DATA_W;
            localparam int unsigned PW = 2 * DW;
            // 2^(DW+BW)/NB_BUCKETS rounded up: bit DW is set, the low DW bits
            // give an exact quotient for every DW-bit value
            localparam logic [PW-1:0] M_FULL =
                ((PW'(1) << (DW + BW)) / PW'(NB_BUCKETS)) + PW'(1);
            localparam logic [DW-1:0] M_LO   = M_FULL[DW-1:0];
            localparam logic [BW-1:0] NB_LO  = BW'(NB_BUCKETS);

            logic [2:0]     r_step;
            logic           r_done;
            logic [DW-1:0]  r_x;
            logic [DW-1:0]  r_t;
            logic [DW-BW:0] r_q;
            logic [BW-1:0]  r_rem;
            logic [DW:0]    w_sum;
            logic [BW-1:0]  w_qn;

            // Quotient is (x + high half of x * reciprocal) >> BW
            assign w_sum = {1'b0, r_x} + {1'b0, r_t};
            assign w_qn  = r_q[BW-1:0] * NB_LO;

            // Advance the step flags; flag completion after the last step
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_step <= '0;
                    r_done <= 1'b0;
                end else begin
                    r_step <= {r_step[1:0], i_start};
                    r_done <= r_step[2];
                end
            end

            // Hold the value, then multiply, shift and subtract in turn
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_x <= i_val;
                end
                if (r_step[0]) begin
                    r_t <= DW'((PW'(r_x) * PW'(M_LO)) >> DW);
                end
                if (r_step[1]) begin
                    r_q <= w_sum[DW:BW];
                end
                if (r_step[2]) begin
                    r_rem <= r_x[BW-1:0] - w_qn;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule
`default_nettype wire

FILE: sv/hash_join_build_probe_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_join_build_probe_unit
// Hashed equi-join engine: loads build tuples into buckets, probes and clears
// them; a probe emits one result word per matching stored tuple or a no-match word.
// ----------------------------------------------------------------------------
// The unit takes one input word at a time and drops ready until that word's
// results are all handed to the output register. The bucket of a load or probe
// is tuple_val mod NB_BUCKETS, found by a mask when NB_BUCKETS is a power of
// two and by a reciprocal multiply in the index unit otherwise.
// A probe scans its bucket one stored tuple a cycle (up to BUCKET_DEPTH), the
// entry memory read port reading one slot at a time, unless a new match must
// wait for the output register. A clear sweeps the bucket fill memory one
// bucket a cycle; the same sweep runs after reset, with ready low. Op code 3 is
// taken and ignored. A result waiting in the output register does not block
// the work of the next word, only the loading of its results.
// ----------------------------------------------------------------------------
module hash_join_build_probe_unit #(
    parameter int unsigned NB_BUCKETS   = hjb_pkg::NB_BUCKETS_DEF,
    parameter int unsigned BUCKET_DEPTH = hjb_pkg::BUCKET_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire hjb_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output hjb_pkg::t_out_word     o_out_data
);

    localparam int unsigned BW = $clog2(NB_BUCKETS);
    localparam int unsigned FW = $clog2(BUCKET_DEPTH + 1);
    localparam int unsigned NE = NB_BUCKETS * BUCKET_DEPTH;
    localparam int unsigned AW = (NE > 1) ? $clog2(NE) : 1;
    localparam int unsigned DW = hjb_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_DISP,
        S_LOAD,
        S_PCMP,
        S_FIN,
        S_CLR,
        S_CEMIT
    } t_state;

    // Sequencer registers and next values
    t_state             r_state, n_state;
    logic [hjb_pkg::OP_W-1:0] r_op, n_op;
    logic [DW-1:0]      r_pkey, n_pkey;
    logic [DW-1:0]      r_pval, n_pval;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_idx, n_idx;
    logic [BW-1:0]      r_sw, n_sw;
    logic               r_clr_emit, n_clr_emit;
    logic               r_pend_v, n_pend_v;
    logic [DW-1:0]      r_pend_key, n_pend_key;
    logic [DW-1:0]      r_pend_val, n_pend_val;
    logic               r_out_v, n_out_v;
    hjb_pkg::t_out_word r_out, n_out;

    // Memories
    logic [FW-1:0]      r_fill_mem [NB_BUCKETS];
    logic [FW-1:0]      r_fill_q;
    logic [DW-1:0]      r_key_mem [NE];
    logic [DW-1:0]      r_val_mem [NE];
    logic [DW-1:0]      r_ek_q;
    logic [DW-1:0]      r_ev_q;

    // Datapath controls
    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    hjb_pkg::t_out_word w_out_word;
    logic               w_rem_start;
    logic               w_rem_done;
    logic [BW-1:0]      w_bucket;
    logic [AW-1:0]      w_base;
    logic [FW-1:0]      w_idx_nx;
    logic [AW-1:0]      w_rd_addr;
    logic [AW-1:0]      w_wr_addr;
    logic               w_rd_en;
    logic               w_rd_first;
    logic               w_ent_wr;
    logic               w_fill_wr;
    logic [BW-1:0]      w_fill_waddr;
    logic [FW-1:0]      w_fill_wdata;
    logic               w_hit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_v || i_out_ready;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Start the bucket index for loads and probes
    assign w_rem_start = w_accept
                         && ((i_in_data.op == hjb_pkg::OP_LOAD)
                             || (i_in_data.op == hjb_pkg::OP_PROBE));

    hjb_rem_unit #(
        .NB_BUCKETS (NB_BUCKETS)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_val   (i_in_data.tuple_val),
        .o_done  (w_rem_done),
        .o_rem   (w_bucket)
    );

    // Form entry addresses from bucket and slot
    assign w_base    = AW'(AW'(w_bucket) * AW'(BUCKET_DEPTH));
    assign w_idx_nx  = r_idx + FW'(1);
    assign w_rd_addr = w_rd_first ? w_base : AW'(w_base + AW'(w_idx_nx));
    assign w_wr_addr = AW'(w_base + AW'(r_fill));
    assign w_hit     = (r_ev_q == r_pval);

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_pkey       = r_pkey;
        n_pval       = r_pval;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_sw         = r_sw;
        n_clr_emit   = r_clr_emit;
        n_pend_v     = r_pend_v;
        n_pend_key   = r_pend_key;
        n_pend_val   = r_pend_val;
        w_out_load   = 1'b0;
        w_out_word   = '0;
        w_rd_en      = 1'b0;
        w_rd_first   = 1'b0;
        w_ent_wr     = 1'b0;
        w_fill_wr    = 1'b0;
        w_fill_waddr = w_bucket;
        w_fill_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = i_in_data.op;
                    n_pkey = i_in_data.tuple_key;
                    n_pval = i_in_data.tuple_val;
                    case (i_in_data.op)
                        hjb_pkg::OP_LOAD:  n_state = S_MOD;
                        hjb_pkg::OP_PROBE: n_state = S_MOD;
                        hjb_pkg::OP_CLEAR: begin
                            n_state    = S_CLR;
                            n_sw       = '0;
                            n_clr_emit = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // Wait for the bucket index; fill read lands on the done edge
            S_MOD: begin
                if (w_rem_done) begin
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_fill   = r_fill_q;
                n_idx    = '0;
                n_pend_v = 1'b0;
                if (r_op == hjb_pkg::OP_LOAD) begin
                    n_state = S_LOAD;
                end else if (r_fill_q == '0) begin
                    n_state = S_FIN;
                end else begin
                    w_rd_en    = 1'b1;
                    w_rd_first = 1'b1;
                    n_state    = S_PCMP;
                end
            end

            // Store the tuple or drop it when the bucket is full
            S_LOAD: begin
                if (w_out_free) begin
                    w_out_load      = 1'b1;
                    w_out_word.last = 1'b1;
                    if (r_fill >= FW'(BUCKET_DEPTH)) begin
                        w_out_word.status = hjb_pkg::ST_FULL;
                    end else begin
                        w_out_word.status = hjb_pkg::ST_LOADED;
                        w_ent_wr          = 1'b1;
                        w_fill_wr         = 1'b1;
                        w_fill_wdata      = r_fill + FW'(1);
                    end
                    n_state = S_IDLE;
                end
            end

            // One slot per cycle unless a match stalls; hold back the newest match
            S_PCMP: begin
                if (!(w_hit && r_pend_v && !w_out_free)) begin
                    if (w_hit) begin
                        if (r_pend_v) begin
                            w_out_load           = 1'b1;
                            w_out_word.status    = hjb_pkg::ST_MATCH;
                            w_out_word.build_key = r_pend_key;
                            w_out_word.build_val = r_pend_val;
                            w_out_word.probe_key = r_pkey;
                            w_out_word.probe_val = r_pval;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_key = r_ek_q;
                        n_pend_val = r_ev_q;
                    end
                    if ((FW+1)'(w_idx_nx) < (FW+1)'(r_fill)) begin
                        w_rd_en = 1'b1;
                        n_idx   = w_idx_nx;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            // Emit the final match or the no-match word
            S_FIN: begin
                if (w_out_free) begin
                    w_out_load           = 1'b1;
                    w_out_word.last      = 1'b1;
                    w_out_word.probe_key = r_pkey;
                    w_out_word.probe_val = r_pval;
                    if (r_pend_v) begin
                        w_out_word.status    = hjb_pkg::ST_MATCH;
                        w_out_word.build_key = r_pend_key;
                        w_out_word.build_val = r_pend_val;
                    end else begin
                        w_out_word.status = hjb_pkg::ST_NOMATCH;
                    end
                    n_state = S_IDLE;
                end
            end

            // Zero every bucket fill, one bucket per cycle
            S_CLR: begin
                w_fill_wr    = 1'b1;
                w_fill_waddr = r_sw;
                w_fill_wdata = '0;
                n_sw         = r_sw + BW'(1);
                if (r_sw == BW'(NB_BUCKETS - 1)) begin
                    n_state = r_clr_emit ? S_CEMIT : S_IDLE;
                end
            end

            S_CEMIT: begin
                if (w_out_free) begin
                    w_out_load        = 1'b1;
                    w_out_word.status = hjb_pkg::ST_CLEARED;
                    w_out_word.last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Output register: load a new word or drain on ready
        n_out_v = r_out_v;
        n_out   = r_out;
        if (w_out_load) begin
            n_out_v = 1'b1;
            n_out   = w_out_word;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_sw       <= '0;
            r_clr_emit <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sw       <= n_sw;
            r_clr_emit <= n_clr_emit;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
        r_op       <= n_op;
        r_pkey     <= n_pkey;
        r_pval     <= n_pval;
        r_fill     <= n_fill;
        r_idx      <= n_idx;
        r_pend_key <= n_pend_key;
        r_pend_val <= n_pend_val;
        r_out      <= n_out;
    end

    // Bucket fill memory
    always_ff @(posedge i_clk) begin
        if (w_fill_wr) begin
            r_fill_mem[w_fill_waddr] <= w_fill_wdata;
        end
        r_fill_q <= r_fill_mem[w_bucket];
    end

    // Stored tuple memories
    always_ff @(posedge i_clk) begin
        if (w_ent_wr) begin
            r_key_mem[w_wr_addr] <= r_pkey;
            r_val_mem[w_wr_addr] <= r_pval;
        end
        if (w_rd_en) begin
            r_ek_q <= r_key_mem[w_rd_addr];
            r_ev_q <= r_val_mem[w_rd_addr];
        end
    end

endmodule
`default_nettype wire
